### rtl/gnms_pkg.sv
// Shared types and constants for the gradient non-max suppression unit.
package gnms_pkg;

  // Field widths
  localparam int MAG_W = 8;
  localparam int ANG_W = 10;
  localparam int CFG_W = 11;

  // Signed width for the wrapped angle (raw 0..1023 before wrapping)
  localparam int ANG_S_W = 12;

  // Angle constants in half-degree units
  localparam logic signed [ANG_S_W-1:0] ANG_HALF_TURN = 12'sd360;  // 180 deg
  localparam logic signed [ANG_S_W-1:0] ANG_FULL_TURN = 12'sd720;  // 360 deg
  localparam logic signed [ANG_S_W-1:0] ANG_B22       = 12'sd45;   // 22.5 deg
  localparam logic signed [ANG_S_W-1:0] ANG_B67       = 12'sd135;  // 67.5 deg
  localparam logic signed [ANG_S_W-1:0] ANG_B112      = 12'sd225;  // 112.5 deg
  localparam logic signed [ANG_S_W-1:0] ANG_B157      = 12'sd315;  // 157.5 deg

  // Saturating row-fill count codes
  localparam logic [1:0] ROWS_NONE = 2'd0;
  localparam logic [1:0] ROWS_ONE  = 2'd1;
  localparam logic [1:0] ROWS_FULL = 2'd2;

  // Smallest legal image width
  localparam int MIN_WIDTH = 3;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef logic [QCNT_W-1:0] qcount_t;

  // Input transaction
  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic [ANG_W-1:0] angle_half_deg;
    logic             in_frame_last;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [MAG_W-1:0] edge_value;
    logic             out_frame_last;
  } out_item_t;

  // One line buffer entry: all three row stores share an address
  typedef struct packed {
    logic [ANG_W-1:0] angle_above;
    logic [MAG_W-1:0] mag_two_above;
    logic [MAG_W-1:0] mag_above;
  } line_t;

  localparam int LINE_W = $bits(line_t);

  // Classified window handed from front to back
  typedef struct packed {
    logic [2:0][2:0][MAG_W-1:0] win;        // [row 0 top..2 newest][col 0 oldest..2 newest]
    logic [ANG_W-1:0]           centre_ang;
    logic                       inner;
    logic                       last;
  } win_item_t;

  typedef struct packed {
    logic      valid;
    win_item_t item;
  } push_t;

endpackage

### rtl/gnms_ram.sv
// Generic simple dual-port RAM with registered read.
module gnms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

### rtl/gnms_front.sv
// Front end: pixel accept, row/column tracking, line buffers and 3x3 window.
module gnms_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  gnms_pkg::in_item_t            in_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gnms_pkg::CFG_W-1:0]    cfg_data,
  input  gnms_pkg::qcount_t             q_count,
  output gnms_pkg::push_t               push
);

  import gnms_pkg::*;

  localparam int AW       = $clog2(MAX_WIDTH);
  localparam int CW       = $clog2(MAX_WIDTH + 1);
  localparam int WW       = (CW > CFG_W) ? CW : CFG_W;
  localparam int RESET_WD = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

  // Configuration and counters
  logic [CW-1:0] width_r, width_nxt;
  logic [AW-1:0] col_r, col_nxt;
  logic [1:0]    rows_r, rows_nxt;

  // Stage 1: item waiting for its line buffer read
  logic             s1_valid_r;
  logic [AW-1:0]    s1_addr_r;
  logic [MAG_W-1:0] s1_mag_r;
  logic [ANG_W-1:0] s1_ang_r;
  logic             s1_last_r;
  logic             s1_emit_r;
  logic             s1_inner_r;

  // Read/write collision bypass
  logic  fwd_hit_r;
  line_t fwd_data_r;

  // Window state
  logic [2:0][2:0][MAG_W-1:0] win_r, win_nxt;
  logic [ANG_W-1:0]           hold_r;

  logic          in_fire;
  logic [WW-1:0] cfg_ext;
  logic          row_end0, row_end1;
  logic [AW-1:0] col_cur;
  logic [1:0]    rows_cur;
  logic [CW-1:0] col_inc;
  logic          emit, inner;
  logic [LINE_W-1:0] ram_q;
  line_t         line_rd, line_wr;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  // Credit: queue occupancy plus the item in stage 1 must leave a slot
  assign in_ready  = (q_count + QCNT_W'(s1_valid_r)) < QCNT_W'(QUEUE_DEPTH);

  // Width write with clamp to the legal range
  always_comb begin
    cfg_ext = WW'(cfg_data);
    if (cfg_ext < WW'(MIN_WIDTH)) begin
      width_nxt = CW'(MIN_WIDTH);
    end else if (cfg_ext > WW'(MAX_WIDTH)) begin
      width_nxt = CW'(MAX_WIDTH);
    end else begin
      width_nxt = CW'(cfg_ext);
    end
  end

  // Column/row position of the incoming pixel and classification
  always_comb begin
    row_end0 = CW'(col_r) >= width_r;
    col_cur  = row_end0 ? '0 : col_r;
    rows_cur = (row_end0 && rows_r != ROWS_FULL) ? rows_r + 2'd1 : rows_r;
    emit     = (rows_cur == ROWS_FULL) || (rows_cur == ROWS_ONE && col_cur != '0);
    inner    = (rows_cur == ROWS_FULL) && (col_cur >= AW'(2));
    col_inc  = CW'(col_cur) + CW'(1);
    row_end1 = col_inc >= width_r;
    if (in_data.in_frame_last) begin
      col_nxt  = '0;
      rows_nxt = ROWS_NONE;
    end else if (row_end1) begin
      col_nxt  = '0;
      rows_nxt = (rows_cur != ROWS_FULL) ? rows_cur + 2'd1 : rows_cur;
    end else begin
      col_nxt  = col_inc[AW-1:0];
      rows_nxt = rows_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= CW'(RESET_WD);
      col_r   <= '0;
      rows_r  <= ROWS_NONE;
    end else begin
      if (cfg_valid) begin
        width_r <= width_nxt;
      end
      if (in_fire) begin
        col_r  <= col_nxt;
        rows_r <= rows_nxt;
      end
    end
  end

  // Stage 1 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
      fwd_hit_r  <= in_fire && s1_valid_r && (col_cur == s1_addr_r);
    end
    fwd_data_r <= line_wr;
    if (in_fire) begin
      s1_addr_r  <= col_cur;
      s1_mag_r   <= in_data.magnitude;
      s1_ang_r   <= in_data.angle_half_deg;
      s1_last_r  <= in_data.in_frame_last;
      s1_emit_r  <= emit;
      s1_inner_r <= inner;
    end
  end

  // Line buffers: read on accept, write back in the following cycle
  gnms_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_addr_r),
    .wr_data (line_wr),
    .rd_en   (in_fire),
    .rd_addr (col_cur),
    .rd_data (ram_q)
  );

  assign line_rd = fwd_hit_r ? fwd_data_r : line_t'(ram_q);

  always_comb begin
    line_wr.angle_above   = s1_ang_r;
    line_wr.mag_two_above = line_rd.mag_above;
    line_wr.mag_above     = s1_mag_r;
  end

  // Window shift: drop oldest column, load the new one
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = line_rd.mag_two_above;
    win_nxt[1][2] = line_rd.mag_above;
    win_nxt[2][2] = s1_mag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      hold_r <= '0;
    end else if (s1_valid_r) begin
      if (s1_last_r) begin
        win_r  <= '0;
        hold_r <= '0;
      end else begin
        win_r  <= win_nxt;
        hold_r <= line_rd.angle_above;
      end
    end
  end

  // Hand emitted windows to the queue
  always_comb begin
    push.valid           = s1_valid_r && s1_emit_r;
    push.item.win        = win_nxt;
    push.item.centre_ang = hold_r;
    push.item.inner      = s1_inner_r;
    push.item.last       = s1_last_r;
  end

endmodule

### rtl/gnms_queue.sv
// Short FIFO of classified windows between front and back.
module gnms_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gnms_pkg::push_t       push,
  input  logic                  pop,
  output gnms_pkg::win_item_t   head,
  output logic                  not_empty,
  output gnms_pkg::qcount_t     count
);

  import gnms_pkg::*;

  win_item_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  qcount_t           count_r;

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = count_r != '0;
  assign count     = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_r + QCNT_W'(push.valid) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.item;
    end
  end

endmodule

### rtl/gnms_back.sv
// Back end: direction sector test, suppression and output register.
module gnms_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gnms_pkg::win_item_t   head,
  input  logic                  not_empty,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gnms_pkg::out_item_t   out_data
);

  import gnms_pkg::*;

  function automatic logic above_both(input logic [MAG_W-1:0] c,
                                      input logic [MAG_W-1:0] p,
                                      input logic [MAG_W-1:0] q);
    return (c > p) && (c > q);
  endfunction

  logic signed [ANG_S_W-1:0] a_raw, a;
  logic                      sec_h, sec_d1, sec_v, sec_d2, keep;
  logic [MAG_W-1:0]          ctr, edge_val;
  logic                      out_valid_r;
  out_item_t                 out_r;

  // Wrap angle into -180..180 degrees
  always_comb begin
    a_raw = ANG_S_W'(head.centre_ang);
    a     = (a_raw > ANG_HALF_TURN) ? a_raw - ANG_FULL_TURN : a_raw;
  end

  // Sector membership; bounds overlap at 22.5 and 112.5, leave gaps at -22.5 and 67.5
  always_comb begin
    sec_h  = (a < -ANG_B157) || (a >= ANG_B157) || ((a > -ANG_B22) && (a <= ANG_B22));
    sec_d1 = ((a < -ANG_B112) && (a >= -ANG_B157)) || ((a >= ANG_B22) && (a < ANG_B67));
    sec_v  = ((a < -ANG_B67) && (a >= -ANG_B112)) || ((a > ANG_B67) && (a <= ANG_B112));
    sec_d2 = ((a < -ANG_B22) && (a >= -ANG_B67)) || ((a >= ANG_B112) && (a < ANG_B157));
    ctr    = head.win[1][1];
    keep   = (sec_h  && above_both(ctr, head.win[1][0], head.win[1][2])) ||
             (sec_d1 && above_both(ctr, head.win[2][0], head.win[0][2])) ||
             (sec_v  && above_both(ctr, head.win[2][1], head.win[0][1])) ||
             (sec_d2 && above_both(ctr, head.win[0][0], head.win[2][2]));
    edge_val = (head.inner && keep) ? ctr : '0;
  end

  // Output register frees up as soon as its transaction is taken
  assign pop = not_empty && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (pop) begin
      out_r.edge_value     <= edge_val;
      out_r.out_frame_last <= head.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### rtl/gradient_non_max_suppression_unit.sv
// Top level of the gradient non-max suppression unit.
//
// Streams raster-order pixels (gradient magnitude plus angle in half-degrees)
// and returns one edge value per pixel once the 3x3 window is full, the
// centre kept only when it beats both neighbours along its gradient sector,
// with border pixels forced to zero. The unit sustains one pixel per clock
// while out_ready is high: the front end does one line buffer read and one
// write-back per cycle on a single two-port RAM of MAX_WIDTH entries, and a
// four-entry queue decouples it from the output register. Pixels pass stage
// 1, the queue and the output register. The first image_width+1 pixels of a
// frame give no result; in_frame_last restarts counting for the next frame.
// image_width is clamped to 3..MAX_WIDTH on write and should be changed only
// while the unit is idle. Line buffers need no clearing after reset.
module gradient_non_max_suppression_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  gnms_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output gnms_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [gnms_pkg::CFG_W-1:0] cfg_data
);

  import gnms_pkg::*;

  push_t     push;
  win_item_t head;
  logic      q_not_empty;
  logic      pop;
  qcount_t   q_count;

  gnms_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_count   (q_count),
    .push      (push)
  );

  gnms_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  gnms_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .not_empty (q_not_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Credit scheme must keep the queue from overflowing
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> (q_count < QCNT_W'(QUEUE_DEPTH)))
    else $error("queue push while full");

  // Every window pushed comes from a pixel accepted the cycle before
  a_push_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> $past(in_valid && in_ready))
    else $error("window pushed without an accepted pixel");

  // Back end only pops an occupied queue
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_not_empty)
    else $error("pop from empty queue");

endmodule
